FILE: src/bresenham_line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer checker.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BRL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/brl_pkg.sv
// Types, constants and the walk step function of the line rasterizer.
`timescale 1ns / 1ps

package brl_pkg;

  // Configuration register indexes.
  localparam logic CfgWindowWidth  = 1'b0;
  localparam logic CfgWindowHeight = 1'b1;

  // Window size after reset.
  localparam logic [7:0] WindowWidthRst  = 8'd80;
  localparam logic [5:0] WindowHeightRst = 6'd20;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  // Position and error term of the line walk.
  typedef struct packed {
    logic [6:0]        x;
    logic [4:0]        y;
    logic signed [9:0] err;
  } brl_walk_t;

  // One result item held in the output register.
  typedef struct packed {
    logic [6:0]        col_a;
    logic signed [5:0] row_a;
    logic              vis_a;
    logic [6:0]        col_b;
    logic signed [5:0] row_b;
    logic              vis_b;
    logic              has_b;
    logic [7:0]        glyph_out;
    logic              last;
  } brl_pair_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic advance;
  } brl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pair_last;
    logic out_free;
  } brl_stat_t;

  // One step of the integer error rule; sx and sy are set for a negative step.
  function automatic brl_walk_t brl_step(brl_walk_t w, logic [6:0] dx, logic [4:0] dy,
                                         logic sx, logic sy);
    brl_walk_t         n;
    logic signed [10:0] e2;
    logic signed [10:0] dx_s;
    logic signed [10:0] dy_s;
    n    = w;
    e2   = {w.err, 1'b0};
    dx_s = signed'({4'b0, dx});
    dy_s = signed'({6'b0, dy});
    if (e2 > -dy_s) begin
      n.err = n.err - dy_s[9:0];
      n.x   = sx ? w.x - 7'd1 : w.x + 7'd1;
    end
    if (e2 < dx_s) begin
      n.err = n.err + dx_s[9:0];
      n.y   = sy ? w.y - 5'd1 : w.y + 5'd1;
    end
    return n;
  endfunction

endpackage

FILE: src/brl_ctrl.sv
// Controller state machine of the line rasterizer.
`timescale 1ns / 1ps

module brl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  brl_pkg::brl_stat_t  stat_i,
  output brl_pkg::brl_cmd_t   cmd_o
);
  import brl_pkg::*;

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StRun  = 1'b1;

  logic [0:0] state_q, state_d;

  // Idle takes a line command; run emits one pair a cycle while the output is free.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (stat_i.out_free) begin
          cmd_o.advance = 1'b1;
          if (stat_i.pair_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/brl_datapath.sv
// Walk registers, two-step rule and output register of the line rasterizer.
`timescale 1ns / 1ps

module brl_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [brl_pkg::InDataW-1:0]      cmd_data_i,
  input  logic [7:0]                       window_width_i,
  input  logic [5:0]                       window_height_i,
  input  brl_pkg::brl_cmd_t                cmd_i,
  output brl_pkg::brl_stat_t               stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output brl_pkg::brl_pair_t               out_o
);
  import brl_pkg::*;

  brl_walk_t  walk_q, walk_d;
  logic [6:0] xe_q, dx_q;
  logic [4:0] ye_q, dy_q;
  logic       sx_q, sy_q;
  logic [7:0] glyph_q;
  brl_pair_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic [6:0] in_sx, in_ex;
  logic [4:0] in_sy, in_ey;
  logic [7:0] in_glyph;
  logic [6:0] in_dx;
  logic [4:0] in_dy;

  brl_walk_t  p1, p2;
  logic       at0, at1;

  // Unpack the line command.
  assign in_sx    = cmd_data_i[6:0];
  assign in_sy    = cmd_data_i[11:7];
  assign in_ex    = cmd_data_i[18:12];
  assign in_ey    = cmd_data_i[23:19];
  assign in_glyph = cmd_data_i[31:24];
  assign in_dx    = (in_ex > in_sx) ? in_ex - in_sx : in_sx - in_ex;
  assign in_dy    = (in_ey > in_sy) ? in_ey - in_sy : in_sy - in_ey;

  // Two dependent steps give the pair of this cycle and the start of the next.
  assign at0 = (walk_q.x == xe_q) && (walk_q.y == ye_q);
  assign p1  = brl_step(walk_q, dx_q, dy_q, sx_q, sy_q);
  assign at1 = (p1.x == xe_q) && (p1.y == ye_q);
  assign p2  = brl_step(p1, dx_q, dy_q, sx_q, sy_q);

  // A line never holds more than 128 points, so the end point always stops it.
  assign stat_o.pair_last = at0 || at1;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // Walk registers.
  always_comb begin
    walk_d = walk_q;
    if (cmd_i.load) begin
      walk_d.x   = in_sx;
      walk_d.y   = in_sy;
      walk_d.err = signed'({3'b0, in_dx}) - signed'({5'b0, in_dy});
    end else if (cmd_i.advance) begin
      walk_d = p2;
    end
  end

  // Result item: screen row is window_height-1-y taken on six bits.
  always_comb begin
    out_d           = out_q;
    out_valid_d     = out_valid_q;
    if (cmd_i.advance) begin
      out_valid_d     = 1'b1;
      out_d.col_a     = walk_q.x;
      out_d.row_a     = signed'(window_height_i - 6'd1 - {1'b0, walk_q.y});
      out_d.vis_a     = ({1'b0, walk_q.x} < window_width_i) &&
                        ({1'b0, walk_q.y} < window_height_i);
      out_d.has_b     = !at0;
      out_d.col_b     = at0 ? '0 : p1.x;
      out_d.row_b     = at0 ? '0 : signed'(window_height_i - 6'd1 - {1'b0, p1.y});
      out_d.vis_b     = !at0 && ({1'b0, p1.x} < window_width_i) &&
                        ({1'b0, p1.y} < window_height_i);
      out_d.glyph_out = glyph_q;
      out_d.last      = at0 || at1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Line parameters are captured with the command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xe_q    <= in_ex;
      ye_q    <= in_ey;
      dx_q    <= in_dx;
      dy_q    <= in_dy;
      sx_q    <= !(in_sx < in_ex);
      sy_q    <= !(in_sy < in_ey);
      glyph_q <= in_glyph;
    end
    walk_q <= walk_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: src/bresenham_line_rasterizer.sv
// A taken line command loads the walk registers, and the output register takes the
// first result item from them. A line of N points gives ceil(N/2) items, one a cycle
// while the output is taken, since two walk steps are done per cycle; the controller
// returns to idle and takes the next command only once the last item enters the output
// register.
// Reset: window 80 by 20, controller idle, output register empty.
`timescale 1ns / 1ps

module bresenham_line_rasterizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  // Line command stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x[6:0], start_y[11:7], end_x[18:12], end_y[23:19], glyph[31:24]
  input  logic [brl_pkg::InDataW-1:0]     s_axis_tdata,
  // Pixel pair stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // col_a[6:0], row_a[12:7], vis_a[13], col_b[20:14], row_b[26:21], vis_b[27],
  // glyph_out[35:28], zero padding[39:36]
  output logic [brl_pkg::OutDataW-1:0]    m_axis_tdata,
  // has_b[0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import brl_pkg::*;

  logic [7:0] window_width_q;
  logic [5:0] window_height_q;
  brl_cmd_t   cmd;
  brl_stat_t  stat;
  brl_pair_t  pair;

  // Window registers; the user must write them only while the block is idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_width_q  <= WindowWidthRst;
      window_height_q <= WindowHeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgWindowWidth:  window_width_q  <= cfg_data_i;
        CfgWindowHeight: window_height_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  brl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  brl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_data_i      (s_axis_tdata),
    .window_width_i  (window_width_q),
    .window_height_i (window_height_q),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_o           (pair)
  );

  // Pack the result item.
  assign m_axis_tdata = {4'b0, pair.glyph_out, pair.vis_b, pair.row_b, pair.col_b,
                         pair.vis_a, pair.row_a, pair.col_a};
  assign m_axis_tuser = pair.has_b;
  assign m_axis_tlast = pair.last;

endmodule

FILE: src/brl_checker.sv
// Port checker of the line rasterizer and its bind to the top level.
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_macros.svh"

module brl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [brl_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);
  import brl_pkg::*;

  logic                in_take;
  logic                out_stall;
  logic                out_single;
  logic [OutDataW+1:0] out_word;

  // Handshake and result item views used by the properties.
  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_single = m_axis_tvalid && !m_axis_tuser;
  assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // Only one line is walked at a time.
  `BRL_ASSERT_NEXT(a_one_line, in_take, !s_axis_tready, "command taken mid-line")

  // A result item without its second point closes the line.
  `BRL_ASSERT_IMPL(a_single_is_last, out_single, m_axis_tlast, "odd point outside final item")

  // An empty second slot carries zeros.
  `BRL_ASSERT_IMPL(a_empty_slot, out_single, m_axis_tdata[27:14] == '0, "empty slot not cleared")

  // A stalled result item holds.
  `BRL_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled item changed")

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (.*);

FILE: bench/brl_raster_checker.sv
// Checker that predicts the pixel pairs of each line command and compares them.
`timescale 1ns / 1ps

module brl_raster_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic                         cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [brl_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [brl_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         m_tuser_i,
  input  logic                         m_tlast_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           lines_o,
  output int                           pairs_o
);
  import brl_pkg::*;

  // Our own copy of the window registers.
  logic [7:0] win_width;
  logic [5:0] win_height;

  // Pixel pairs still owed by the block, oldest first.
  brl_pair_t pairs_due[$];

  // One line per mismatch; the count goes on after printing stops.
  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) begin
      $display("%0t ERROR pair %0d: %s", $time, pairs_o, msg);
    end
    fail_count_o++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Row flip, kept to six bits as two's complement.
  function automatic logic [5:0] screen_row(input logic [4:0] y);
    return win_height - 6'd1 - {1'b0, y};
  endfunction

  function automatic logic in_window(input logic [6:0] x, input logic [4:0] y);
    return ({1'b0, x} < win_width) && ({1'b0, y} < win_height);
  endfunction

  // Walk the error rule from start to end and queue the pixel pairs it gives.
  task automatic rasterise_line(input logic [InDataW-1:0] cmd);
    logic [6:0] x;
    logic [6:0] x_end;
    logic [4:0] y;
    logic [4:0] y_end;
    logic [7:0] glyph;
    logic       step_left;
    logic       step_down;
    int         dx;
    int         dy;
    int         err;
    int         e2;
    int         n_points;
    brl_pair_t  pair;
    x         = cmd[6:0];
    y         = cmd[11:7];
    x_end     = cmd[18:12];
    y_end     = cmd[23:19];
    glyph     = cmd[31:24];
    dx        = (x_end > x) ? int'(x_end) - int'(x) : int'(x) - int'(x_end);
    dy        = (y_end > y) ? int'(y_end) - int'(y) : int'(y) - int'(y_end);
    step_left = x_end < x;
    step_down = y_end < y;
    err       = dx - dy;
    // Each step moves one unit along the major axis.
    n_points  = ((dx > dy) ? dx : dy) + 1;
    pair      = '0;
    for (int k = 0; k < n_points; k++) begin
      if (k % 2 == 0) begin
        pair           = '0;
        pair.col_a     = x;
        pair.row_a     = screen_row(y);
        pair.vis_a     = in_window(x, y);
        pair.glyph_out = glyph;
      end else begin
        pair.col_b = x;
        pair.row_b = screen_row(y);
        pair.vis_b = in_window(x, y);
        pair.has_b = 1'b1;
      end
      if (k % 2 == 1 || k == n_points - 1) begin
        pair.last = (k == n_points - 1);
        pairs_due.push_back(pair);
      end
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x = step_left ? x - 7'd1 : x + 7'd1;
      end
      if (e2 < dx) begin
        err += dx;
        y = step_down ? y - 5'd1 : y + 5'd1;
      end
    end
  endtask

  // Compare one accepted pair item with the oldest one owed.
  task automatic check_pair();
    brl_pair_t want;
    if (pairs_due.size() == 0) begin
      report_mismatch($sformatf("item 0x%0h arrived with nothing owed", m_tdata_i));
      return;
    end
    want = pairs_due.pop_front();
    compare_field("col_a", m_tdata_i[6:0], want.col_a);
    compare_field("row_a", m_tdata_i[12:7], unsigned'(want.row_a));
    compare_field("vis_a", m_tdata_i[13], want.vis_a);
    compare_field("col_b", m_tdata_i[20:14], want.col_b);
    compare_field("row_b", m_tdata_i[26:21], unsigned'(want.row_b));
    compare_field("vis_b", m_tdata_i[27], want.vis_b);
    compare_field("glyph_out", m_tdata_i[35:28], want.glyph_out);
    compare_field("padding", m_tdata_i[39:36], 0);
    compare_field("has_b", m_tuser_i, want.has_b);
    compare_field("last", m_tlast_i, want.last);
  endtask

  // Watch the three channels on each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_width    = WindowWidthRst;
      win_height   = WindowHeightRst;
      pairs_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      lines_o      = 0;
      pairs_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgWindowWidth) begin
          win_width = cfg_data_i;
        end else begin
          win_height = cfg_data_i[5:0];
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        rasterise_line(s_tdata_i);
        lines_o++;
      end
      if (m_tvalid_i && m_tready_i) begin
        check_pair();
        pairs_o++;
      end
      pending_o = pairs_due.size();
    end
  end

endmodule

FILE: bench/tb_bresenham_line_rasterizer.sv
// Top of the line rasterizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;
  import brl_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 16;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i   = CfgWindowWidth;
  logic [7:0]          cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  int fail_count;
  int pending;
  int lines_seen;
  int pairs_seen;
  int windows_set   = 0;
  int quiet_cycles  = 0;
  bit calm          = 1'b0;
  bit hold_off_req  = 1'b0;

  bresenham_line_rasterizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  brl_raster_checker pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .lines_o      (lines_seen),
    .pairs_o      (pairs_seen)
  );

  always #1 clk_i = ~clk_i;

  // Give up when nothing at all is accepted for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("FAIL bresenham_line_rasterizer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pair sink: random stalls per item, none in calm stretches, one long hold-off on request.
  initial begin : pair_sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall        = HoldOffCycles;
        hold_off_req = 1'b0;
      end else if (calm) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Write both window registers back to back.
  task automatic set_window(input logic [7:0] width, input logic [7:0] height);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgWindowWidth;
    cfg_data_i  <= width;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_index_i <= CfgWindowHeight;
    cfg_data_i  <= height;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    windows_set++;
  endtask

  // Offer one line command after a random gap, and wait until it is taken.
  task automatic send_line(input logic [6:0] x0, input logic [4:0] y0,
                           input logic [6:0] x1, input logic [4:0] y1,
                           input logic [7:0] glyph);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {glyph, y1, x1, y0, x0};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Mostly short lines around a random start, sometimes any two points.
  task automatic send_random_line();
    int x0;
    int y0;
    int x1;
    int y1;
    x0 = $urandom_range(0, 127);
    y0 = $urandom_range(0, 31);
    if ($urandom_range(0, 3) == 0) begin
      x1 = $urandom_range(0, 127);
      y1 = $urandom_range(0, 31);
    end else begin
      x1 = x0 + int'($urandom_range(0, 24)) - 12;
      y1 = y0 + int'($urandom_range(0, 12)) - 6;
      if (x1 < 0) x1 = 0;
      if (x1 > 127) x1 = 127;
      if (y1 < 0) y1 = 0;
      if (y1 > 31) y1 = 31;
    end
    if ($urandom_range(0, 19) == 0) calm = !calm;
    send_line(7'(x0), 5'(y0), 7'(x1), 5'(y1), 8'($urandom_range(0, 255)));
  endtask

  // Stop offering and let every owed pair come out before going on.
  task automatic drain_lines();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the reset window: single points, extremes, steep and shallow slopes.
    send_line(7'd0, 5'd0, 7'd0, 5'd0, 8'h00);
    send_line(7'd127, 5'd31, 7'd127, 5'd31, 8'hFF);
    send_line(7'd0, 5'd0, 7'd127, 5'd0, 8'hAA);
    send_line(7'd127, 5'd31, 7'd0, 5'd31, 8'h55);
    send_line(7'd5, 5'd0, 7'd5, 5'd31, 8'h01);
    send_line(7'd5, 5'd31, 7'd5, 5'd0, 8'h80);
    send_line(7'd0, 5'd0, 7'd31, 5'd31, 8'h2A);
    send_line(7'd31, 5'd31, 7'd0, 5'd0, 8'h23);
    send_line(7'd0, 5'd0, 7'd1, 5'd0, 8'h7F);
    send_line(7'd0, 5'd0, 7'd2, 5'd0, 8'hFE);
    send_line(7'd10, 5'd5, 7'd3, 5'd20, 8'h40);
    send_line(7'd60, 5'd25, 7'd70, 5'd2, 8'h10);
    send_line(7'd100, 5'd3, 7'd40, 5'd12, 8'h08);
    send_line(7'd70, 5'd10, 7'd90, 5'd25, 8'h04);
    send_line(7'd0, 5'd31, 7'd127, 5'd0, 8'h02);
    send_line(7'd127, 5'd0, 7'd0, 5'd31, 8'h20);
    // Straddles the corner of the 80 by 20 window.
    send_line(7'd79, 5'd19, 7'd80, 5'd20, 8'hC3);
    drain_lines();

    // Widest window; the sink holds off while long lines keep coming.
    set_window(8'd128, 8'd32);
    calm         = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_line(7'd0, 5'(i), 7'd127, 5'(31 - i), 8'(8'h30 + i));
    end
    calm = 1'b0;
    repeat (60) send_random_line();
    drain_lines();

    // One-pixel window: almost everything falls outside.
    set_window(8'd1, 8'd1);
    repeat (30) send_random_line();
    drain_lines();

    // Zero width, then zero height: points still come, none visible.
    set_window(8'd0, 8'd20);
    repeat (10) send_random_line();
    drain_lines();
    set_window(8'd128, 8'd0);
    repeat (10) send_random_line();
    drain_lines();

    // Height beyond the screen, so the row flip wraps.
    set_window(8'd100, 8'd63);
    repeat (15) send_random_line();
    drain_lines();

    // Random windows within the usual range.
    repeat (5) begin
      set_window(8'($urandom_range(1, 128)), 8'($urandom_range(1, 32)));
      repeat (30) send_random_line();
      drain_lines();
    end

    $display("Ran %0d line commands, giving %0d pixel pair items, over %0d window settings,",
             lines_seen, pairs_seen, windows_set);
    $display("with random stalls on both streams and one %0d-cycle output hold-off.",
             HoldOffCycles);
    if (fail_count == 0) begin
      $display("PASS bresenham_line_rasterizer");
    end else begin
      $display("FAIL bresenham_line_rasterizer");
    end
    $finish;
  end

endmodule
